// ===== design/tpsi_pkg.sv =====
// Shared types and constants for the tolerant point set insert unit.
`timescale 1ns / 1ps

package tpsi_pkg;

   localparam int COORD_W   = 32;
   localparam int TOL_W     = 31;
   localparam int MAG_W     = 32;
   localparam int SQ_W      = 64;
   localparam int CNT_OUT_W = 7;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic [1:0] TERM_X = 2'd0;
   localparam logic [1:0] TERM_Y = 2'd1;
   localparam logic [1:0] TERM_Z = 2'd2;

   typedef struct packed {
      logic                      operation;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic                 added;
      logic                 set_full;
      logic [CNT_OUT_W-1:0] stored_count;
   } rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } point_type;

   // Commands from the sequencer to the distance unit.
   typedef struct packed {
      logic       load_diff;
      logic       mul_tol;
      logic [1:0] mul_sel;
      logic       acc_clear;
      logic       acc_add;
      logic       save_tolsq;
   } dist_ctrl_type;

   typedef struct packed {
      logic far;
      logic close;
   } dist_stat_type;

endpackage

// ===== design/tpsi_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module tpsi_ram #(
   parameter int   WIDTH = 32,
   parameter int   DEPTH = 64,
   localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tpsi_dist_unit.sv =====
// Distance unit: coordinate differences, one shared squarer and the accumulator.
`timescale 1ns / 1ps

module tpsi_dist_unit (
   input  logic                        clock,
   input  tpsi_pkg::dist_ctrl_type     ctrl,
   input  tpsi_pkg::point_type         new_point,
   input  tpsi_pkg::point_type         stored_point,
   input  logic [tpsi_pkg::TOL_W-1:0]  tolerance,
   output tpsi_pkg::dist_stat_type     status
);

   import tpsi_pkg::*;

   logic [MAG_W-1:0] mag_in [3];
   logic [MAG_W-1:0] mag_ff [3];
   logic             far_in;
   logic             far_ff;
   logic [MAG_W-1:0] op_a;
   logic [SQ_W-1:0]  prod_in;
   logic [SQ_W-1:0]  prod_ff;
   logic [SQ_W-1:0]  acc_ff;
   logic [SQ_W-1:0]  tolsq_ff;

   function automatic logic [MAG_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
      logic [COORD_W:0] d;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      if (d[COORD_W]) begin
         d = ~d + (COORD_W+1)'(1);
      end
      return MAG_W'(d);
   endfunction

   always_comb begin
      mag_in[0] = abs_diff(stored_point.x, new_point.x);
      mag_in[1] = abs_diff(stored_point.y, new_point.y);
      mag_in[2] = abs_diff(stored_point.z, new_point.z);
      // A single axis at or beyond the tolerance rules the pair out at once.
      far_in = (mag_in[0] >= {1'b0, tolerance}) ||
               (mag_in[1] >= {1'b0, tolerance}) ||
               (mag_in[2] >= {1'b0, tolerance});
   end

   always_comb begin
      if (ctrl.mul_tol) begin
         op_a = {1'b0, tolerance};
      end else begin
         case (ctrl.mul_sel)
            TERM_X:  op_a = mag_ff[0];
            TERM_Y:  op_a = mag_ff[1];
            TERM_Z:  op_a = mag_ff[2];
            default: op_a = mag_ff[0];
         endcase
      end
      prod_in = op_a * op_a;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_diff) begin
         mag_ff[0] <= mag_in[0];
         mag_ff[1] <= mag_in[1];
         mag_ff[2] <= mag_in[2];
         far_ff    <= far_in;
      end
      prod_ff <= prod_in;
      if (ctrl.save_tolsq) begin
         tolsq_ff <= prod_ff;
      end
      if (ctrl.acc_clear) begin
         acc_ff <= '0;
      end else if (ctrl.acc_add) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   assign status.far   = far_ff;
   assign status.close = (acc_ff < tolsq_ff);

endmodule

// ===== design/tolerant_point_set_insert_unit.sv =====
// Top level of the tolerant point set insert unit: sequencer, count and point store.
`timescale 1ns / 1ps

// Usage: a request is taken when start is high and busy is low. An insert
// request (operation 0) compares its point with each stored point in turn and
// appends it when none lies closer than the tolerance and the set has room; a
// clear request (operation 1) empties the set. Each request yields one result,
// shown on rsp_payload for a single cycle with rsp_strobe high; the receiver
// cannot stall it, so it must take the result in that cycle.
// Timing: a clear request keeps busy low and gives its result in the next cycle.
// An insert request keeps busy high while it searches; entries that a single axis
// rules out skip the full squared distance, and the search stops at the first
// match. All squares go through one shared 32 by 32 multiplier, three per entry
// plus one for the squared tolerance. The result appears in the first cycle in
// which busy is low again, and a new request may be taken in that same cycle.
// The tolerance register is written through csr_wr_en and csr_wr_data; the user
// must write it only while the unit is idle, as the block does not enforce this.
// Reset empties the set and loads a tolerance of 1 LSB.
module tolerant_point_set_insert_unit #(
   parameter int CAPACITY = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  tpsi_pkg::req_type           req_payload,
   output logic                        rsp_strobe,
   output tpsi_pkg::rsp_type           rsp_payload,
   input  logic                        csr_wr_en,
   input  logic [tpsi_pkg::TOL_W-1:0]  csr_wr_data
);

   import tpsi_pkg::*;

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int PT_W   = 3 * COORD_W;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_TOLSQ   = 3'd1;
   localparam logic [2:0] ST_TOLSAVE = 3'd2;
   localparam logic [2:0] ST_READ    = 3'd3;
   localparam logic [2:0] ST_DIFF    = 3'd4;
   localparam logic [2:0] ST_MUL     = 3'd5;
   localparam logic [2:0] ST_SUM     = 3'd6;
   localparam logic [2:0] ST_CMP     = 3'd7;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [1:0]        term_ff, term_in;
   logic [TOL_W-1:0]  tol_ff;
   point_type         point_ff;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   dist_ctrl_type     dctrl;
   dist_stat_type     dstat;
   point_type         stored_point;
   logic              wr_en;
   logic [PT_W-1:0]   rd_data;

   assign stored_point = point_type'(rd_data);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      term_in       = term_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      dctrl         = '0;
      dctrl.mul_sel = term_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_payload.operation == OP_CLEAR) begin
                  count_in      = '0;
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '{added: 1'b0, set_full: 1'b0, stored_count: '0};
               end else begin
                  idx_in   = '0;
                  state_in = ST_TOLSQ;
               end
            end
         end
         ST_TOLSQ: begin
            dctrl.mul_tol = 1'b1;
            state_in      = ST_TOLSAVE;
         end
         ST_TOLSAVE: begin
            dctrl.save_tolsq = 1'b1;
            state_in         = ST_READ;
         end
         ST_READ: begin
            if (idx_ff == count_ff) begin
               // No stored point matched: append, or refuse when the set is full.
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
               if (count_ff == CNT_W'(CAPACITY)) begin
                  rsp_in = '{added: 1'b0, set_full: 1'b1,
                             stored_count: CNT_OUT_W'(count_ff)};
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  rsp_in   = '{added: 1'b1, set_full: 1'b0,
                               stored_count: CNT_OUT_W'(count_ff + CNT_W'(1))};
               end
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            dctrl.load_diff = 1'b1;
            term_in         = TERM_X;
            state_in        = ST_MUL;
         end
         ST_MUL: begin
            if (dstat.far) begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_READ;
            end else begin
               // The product of the previous term is added while the next is squared.
               dctrl.acc_clear = (term_ff == TERM_X);
               dctrl.acc_add   = (term_ff != TERM_X);
               if (term_ff == TERM_Z) begin
                  state_in = ST_SUM;
               end else begin
                  term_in = term_ff + 2'd1;
               end
            end
         end
         ST_SUM: begin
            dctrl.acc_add = 1'b1;
            state_in      = ST_CMP;
         end
         ST_CMP: begin
            if (dstat.close) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{added: 1'b0, set_full: 1'b0,
                                 stored_count: CNT_OUT_W'(count_ff)};
               state_in      = ST_IDLE;
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         term_ff       <= TERM_X;
         tol_ff        <= TOL_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         term_ff       <= term_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (state_ff == ST_IDLE && start) begin
         point_ff <= '{x: req_payload.point_x, y: req_payload.point_y,
                       z: req_payload.point_z};
      end
   end

   tpsi_ram #(
      .WIDTH (PT_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (PT_W'(point_ff)),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   tpsi_dist_unit u_dist (
      .clock        (clock),
      .ctrl         (dctrl),
      .new_point    (point_ff),
      .stored_point (stored_point),
      .tolerance    (tol_ff),
      .status       (dstat)
   );

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== tb/tb_tolerant_point_set_insert_unit.sv =====
// Self-checking testbench for the tolerant point set insert unit.
`timescale 1ns / 1ps

module tb_tolerant_point_set_insert_unit;

   import tpsi_pkg::*;

   localparam int     CAPACITY        = 64;
   localparam int     RANDOM_REQUESTS = 1180;
   localparam int     QUIET_TAIL      = 150;
   localparam int     SETTLE_CYCLES   = 3 + 7 * CAPACITY + 10;
   localparam longint CYCLE_LIMIT     = 2_500_000;

   localparam logic [COORD_W-1:0] C_MAX  = 32'h7FFF_FFFF;
   localparam logic [COORD_W-1:0] C_MIN  = 32'h8000_0000;
   localparam logic [COORD_W-1:0] C_NEG1 = 32'hFFFF_FFFF;
   localparam logic [COORD_W-1:0] C_NEG2 = 32'hFFFF_FFFE;
   localparam logic [TOL_W-1:0]   TOL_MAX = '1;

   typedef struct {
      bit                  tol_wr;
      logic [TOL_W-1:0]    tol_val;
      logic                op;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COORD_W-1:0]  z;
      bit                  typed;
      logic                added;
      logic                full;
      logic [CNT_OUT_W-1:0] count;
   } script_row_type;

   localparam int SCRIPT_LEN = 21;

   // Rows with typed set to 0 take their expected result from the predictor.
   script_row_type script [SCRIPT_LEN] = '{
      '{1'b0, '0,           OP_CLEAR,  32'hDEAD_BEEF, 32'h1234_5678, C_MIN, 1'b1, 1'b0, 1'b0, 7'd0},
      '{1'b0, '0,           OP_INSERT, '0,     '0,     '0,     1'b1, 1'b1, 1'b0, 7'd1},
      '{1'b0, '0,           OP_INSERT, '0,     '0,     '0,     1'b1, 1'b0, 1'b0, 7'd1},
      '{1'b0, '0,           OP_INSERT, 32'd1,  '0,     '0,     1'b1, 1'b1, 1'b0, 7'd2},
      '{1'b0, '0,           OP_INSERT, C_MAX,  C_MIN,  C_NEG1, 1'b1, 1'b1, 1'b0, 7'd3},
      '{1'b0, '0,           OP_INSERT, C_MIN,  C_MAX,  C_MAX,  1'b1, 1'b1, 1'b0, 7'd4},
      '{1'b0, '0,           OP_INSERT, C_MAX,  C_MIN,  C_NEG1, 1'b1, 1'b0, 1'b0, 7'd4},
      '{1'b1, '0,           OP_INSERT, '0,     '0,     '0,     1'b1, 1'b1, 1'b0, 7'd5},
      '{1'b0, '0,           OP_CLEAR,  C_NEG1, C_NEG1, C_NEG1, 1'b1, 1'b0, 1'b0, 7'd0},
      '{1'b1, TOL_MAX,      OP_INSERT, '0,     '0,     '0,     1'b1, 1'b1, 1'b0, 7'd1},
      '{1'b0, '0,           OP_INSERT, C_MAX,  '0,     '0,     1'b1, 1'b1, 1'b0, 7'd2},
      '{1'b0, '0,           OP_INSERT, C_MIN,  '0,     '0,     1'b1, 1'b1, 1'b0, 7'd3},
      '{1'b0, '0,           OP_INSERT, 32'h4000_0000, '0, '0,  1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, '0,           OP_INSERT, 32'd1,  32'd1,  32'd1,  1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, '0,           OP_INSERT, '0,     C_MIN,  C_MAX,  1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b1, TOL_W'(3),    OP_CLEAR,  32'h5555_5555, 32'hAAAA_AAAA, '0, 1'b1, 1'b0, 1'b0, 7'd0},
      '{1'b0, '0,           OP_INSERT, '0,     '0,     '0,     1'b1, 1'b1, 1'b0, 7'd1},
      '{1'b0, '0,           OP_INSERT, 32'd2,  32'd2,  '0,     1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, '0,           OP_INSERT, 32'd2,  32'd2,  32'd1,  1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b0, '0,           OP_INSERT, C_NEG2, '0,     '0,     1'b0, 1'b0, 1'b0, 7'd0},
      '{1'b1, TOL_W'(1),    OP_INSERT, '0,     '0,     '0,     1'b0, 1'b0, 1'b0, 7'd0}
   };

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_payload;
   logic               rsp_strobe;
   rsp_type            rsp_payload;
   logic               csr_wr_en;
   logic [TOL_W-1:0]   csr_wr_data;

   // Predicted contents of the point set and the tolerance register.
   logic [COORD_W-1:0] held_x [CAPACITY];
   logic [COORD_W-1:0] held_y [CAPACITY];
   logic [COORD_W-1:0] held_z [CAPACITY];
   int                 held_count  = 0;
   logic [TOL_W-1:0]   tolerance_q = TOL_RESET;

   rsp_type            expected_results [$];
   int                 mismatches  = 0;
   longint             cycle_count = 0;

   tolerant_point_set_insert_unit #(
      .CAPACITY (CAPACITY)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   function automatic longint coord_gap(input logic [COORD_W-1:0] a,
                                        input logic [COORD_W-1:0] b);
      longint d;
      d = longint'($signed(a)) - longint'($signed(b));
      return (d < 0) ? -d : d;
   endfunction

   // Two points match when the squared distance is strictly below the squared
   // tolerance; one axis at or beyond the tolerance rules the entry out early.
   function automatic bit point_is_near(input int idx, input req_type r);
      longint     tol;
      longint     dx;
      longint     dy;
      longint     dz;
      logic [63:0] sq_sum;
      tol = longint'(tolerance_q);
      dx  = coord_gap(held_x[idx], r.point_x);
      dy  = coord_gap(held_y[idx], r.point_y);
      dz  = coord_gap(held_z[idx], r.point_z);
      if (dx >= tol || dy >= tol || dz >= tol) begin
         return 1'b0;
      end
      sq_sum = 64'(dx * dx) + 64'(dy * dy) + 64'(dz * dz);
      return sq_sum < 64'(tol * tol);
   endfunction

   function automatic rsp_type point_set_apply(input req_type r);
      rsp_type res;
      bit      dup;
      res = '0;
      dup = 1'b0;
      if (r.operation == OP_CLEAR) begin
         held_count = 0;
      end else begin
         for (int i = 0; i < held_count && !dup; i++) begin
            dup = point_is_near(i, r);
         end
         if (!dup) begin
            if (held_count >= CAPACITY) begin
               res.set_full = 1'b1;
            end else begin
               held_x[held_count] = r.point_x;
               held_y[held_count] = r.point_y;
               held_z[held_count] = r.point_z;
               held_count++;
               res.added = 1'b1;
            end
         end
      end
      res.stored_count = CNT_OUT_W'(held_count);
      return res;
   endfunction

   // Offset a coordinate by up to the given span, landing exactly on it now and then.
   function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] base,
                                                     input int unsigned span);
      longint off;
      if ($urandom_range(0, 3) == 0) begin
         off = $urandom_range(0, 1) ? longint'(span) : -longint'(span);
      end else begin
         off = longint'($urandom_range(0, 2 * span)) - longint'(span);
      end
      return base + COORD_W'(off);
   endfunction

   function automatic logic [COORD_W-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return C_MAX;
         2: return C_MIN;
         3: return C_NEG1;
         default: return 32'd1;
      endcase
   endfunction

   function automatic logic [TOL_W-1:0] pick_tolerance();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return TOL_W'(1);
         2: return TOL_MAX;
         3: return TOL_W'($urandom_range(2, 300));
         4: return TOL_W'($urandom);
         default: return TOL_W'($urandom_range(1 << 10, 1 << 24));
      endcase
   endfunction

   function automatic req_type clear_request();
      req_type r;
      r.operation = OP_CLEAR;
      r.point_x   = $urandom;
      r.point_y   = $urandom;
      r.point_z   = $urandom;
      return r;
   endfunction

   function automatic req_type random_point_request();
      req_type     r;
      int          mode;
      int          idx;
      int unsigned span;
      mode        = $urandom_range(0, 99);
      span        = tolerance_q;
      r.operation = OP_INSERT;
      if (mode < 45 && held_count > 0) begin
         idx       = $urandom_range(0, held_count - 1);
         r.point_x = near_coord(held_x[idx], span);
         r.point_y = near_coord(held_y[idx], span);
         r.point_z = near_coord(held_z[idx], span);
      end else if (mode < 75) begin
         r.point_x = $urandom;
         r.point_y = $urandom;
         r.point_z = $urandom;
      end else if (mode < 85) begin
         r.point_x = pick_extreme();
         r.point_y = pick_extreme();
         r.point_z = pick_extreme();
      end else begin
         span      = (tolerance_q >= 31'h3FFF_FFF0) ? 32'h7FFF_FFFF : 2 * span + 4;
         r.point_x = near_coord('0, span);
         r.point_y = near_coord('0, span);
         r.point_z = near_coord('0, span);
      end
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance with start still high.
   task automatic issue_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      rsp_type predicted;
      req_payload = r;
      start       = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = point_set_apply(r);
      expected_results.push_back(typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic sender_pause(input int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic drain_results();
      start = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_tolerance(input logic [TOL_W-1:0] value);
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      tolerance_q = value;
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with no request outstanding", rsp_payload.stored_count, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_payload.added !== want.added) begin
               report_mismatch("added", rsp_payload.added, want.added);
            end
            if (rsp_payload.set_full !== want.set_full) begin
               report_mismatch("set_full", rsp_payload.set_full, want.set_full);
            end
            if (rsp_payload.stored_count !== want.stored_count) begin
               report_mismatch("stored_count", rsp_payload.stored_count, want.stored_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      req_type          r;
      rsp_type          want;
      logic [TOL_W-1:0] tol;
      int               sent;
      int               phase;
      int               len;
      bit               gaps_on;

      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[k]) begin
         if (script[k].tol_wr) begin
            drain_results();
            load_tolerance(script[k].tol_val);
         end
         r.operation       = script[k].op;
         r.point_x         = script[k].x;
         r.point_y         = script[k].y;
         r.point_z         = script[k].z;
         want.added        = script[k].added;
         want.set_full     = script[k].full;
         want.stored_count = script[k].count;
         issue_request(r, script[k].typed, want);
      end

      // The first phase fills the set at zero tolerance and runs past capacity;
      // the second keeps it full at the widest tolerance.
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_REQUESTS) begin
         if (RANDOM_REQUESTS - sent > QUIET_TAIL) begin
            drain_results();
            case (phase)
               0:       tol = '0;
               1:       tol = TOL_MAX;
               default: tol = pick_tolerance();
            endcase
            load_tolerance(tol);
            if (phase == 0 || (phase > 1 && $urandom_range(0, 9) < 6)) begin
               issue_request(clear_request(), 1'b0, '0);
               sent++;
            end
         end
         len     = (phase == 0) ? CAPACITY + 6 : $urandom_range(20, 130);
         gaps_on = $urandom_range(0, 3) != 0;
         for (int i = 0; i < len && sent < RANDOM_REQUESTS; i++) begin
            if (RANDOM_REQUESTS - sent > QUIET_TAIL) begin
               if (gaps_on && $urandom_range(0, 2) == 0) begin
                  sender_pause($urandom_range(1, 14));
               end
               if ($urandom_range(0, 99) == 0) begin
                  drain_results();
               end
            end
            if (phase > 1 && $urandom_range(0, 79) == 0) begin
               r = clear_request();
            end else begin
               r = random_point_request();
            end
            issue_request(r, 1'b0, '0);
            sent++;
         end
         phase++;
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tpsi_pkg.sv
design/tpsi_ram.sv
design/tpsi_dist_unit.sv
design/tolerant_point_set_insert_unit.sv
tb/tb_tolerant_point_set_insert_unit.sv
